// ----- rtl/tcpm_pkg.sv -----
// Shared types and constants for the two-channel pixel mixer.
// Holds mix mode codes, register map codes and fixed-point division constants.
// No dependencies.
package tcpm_pkg;

	// Mix mode codes; codes five to seven act as channel 1 only
	typedef enum logic [2:0] {
		MODE_CH1 = 3'd0,
		MODE_CH2 = 3'd1,
		MODE_ADD = 3'd2,
		MODE_SUB = 3'd3,
		MODE_MUL = 3'd4
	} mix_mode_t;

	// Register map, word index on the APB port
	typedef enum logic [2:0] {
		REG_MIX_MODE   = 3'd0,
		REG_MIX_PCT    = 3'd1,
		REG_EFFECTS    = 3'd2,
		REG_CONTRAST   = 3'd3,
		REG_BRIGHTNESS = 3'd4,
		REG_OFFSET_C0  = 3'd5,
		REG_OFFSET_C1  = 3'd6,
		REG_OFFSET_C2  = 3'd7
	} reg_idx_t;

	localparam int unsigned NUM_COMP = 3;
	localparam int unsigned ADDR_W   = 5;
	localparam int unsigned DATA_W   = 32;

	// floor(n/100) == (n*DIV100_MUL) >> DIV100_SHIFT, exact for n below 61008
	localparam int unsigned DIV_IN_W     = 15;
	localparam int unsigned DIV100_MUL_W = 22;
	localparam int unsigned DIV_PROD_W   = DIV_IN_W + DIV100_MUL_W;
	localparam int unsigned DIV100_SHIFT = 28;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 22'd2684355;

	// Reset values of the registers
	localparam logic [2:0] RST_MIX_MODE   = 3'd0;
	localparam logic [6:0] RST_MIX_PCT    = 7'd50;
	localparam logic [1:0] RST_EFFECTS    = 2'd0;
	localparam logic [7:0] RST_CONTRAST   = 8'd100;
	localparam logic [7:0] RST_BRIGHTNESS = 8'd100;
	localparam logic [7:0] RST_OFFSET     = 8'd100;

	localparam logic [6:0] PCT_FULL     = 7'd100;
	localparam logic [7:0] PIX_MAX      = 8'd255;
	localparam logic [7:0] OFS_PIX_MAX  = 8'd254;
	localparam logic [7:0] ROUND_HALF   = 8'd50;
	localparam logic [16:0] BRIGHT_BIAS = 17'd10000;
	localparam logic [16:0] SAT_LIMIT   = 17'd25600;

	// Quotient bits of a reciprocal product, saturated to a pixel value
	function automatic logic [7:0] quot_sat(input logic [DIV_PROD_W-1:0] prod);
		logic [DIV_PROD_W-DIV100_SHIFT-1:0] q;
		q = prod[DIV_PROD_W-1:DIV100_SHIFT];
		quot_sat = (q > {1'b0, PIX_MAX}) ? PIX_MAX : q[7:0];
	endfunction

endpackage

// ----- rtl/two_channel_pixel_mixer_core.sv -----
// Two-channel pixel mixer core: mix, contrast/brightness and offset pipeline.
// Depends on tcpm_pkg for mode codes, register map and division constants.
//
// Throughput: one pixel per clock; busy is always low since every stage
// advances each cycle and the receiver cannot stall.
// Reset: arst_n clears all valid bits and loads the register reset values.
module two_channel_pixel_mixer_core (
	input  logic                        clk,
	input  logic                        arst_n,
	// pixel request
	input  logic                        start,
	output logic                        busy,
	input  logic [7:0]                  first_c0,
	input  logic [7:0]                  first_c1,
	input  logic [7:0]                  first_c2,
	input  logic [7:0]                  second_c0,
	input  logic [7:0]                  second_c1,
	input  logic [7:0]                  second_c2,
	// result strobe
	output logic                        done,
	output logic [7:0]                  mixed_c0,
	output logic [7:0]                  mixed_c1,
	output logic [7:0]                  mixed_c2,
	// APB configuration port
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tcpm_pkg::ADDR_W-1:0] paddr,
	input  logic [tcpm_pkg::DATA_W-1:0] pwdata,
	output logic [tcpm_pkg::DATA_W-1:0] prdata,
	output logic                        pready
);
	import tcpm_pkg::*;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [2:0] mix_mode_q;
	logic [6:0] mix_pct_q;
	logic [1:0] effects_q;
	logic [7:0] contrast_q;
	logic [7:0] brightness_q;
	logic [7:0] offset_q [NUM_COMP];

	logic       cfg_wr;
	reg_idx_t   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_mode_q   <= RST_MIX_MODE;
			mix_pct_q    <= RST_MIX_PCT;
			effects_q    <= RST_EFFECTS;
			contrast_q   <= RST_CONTRAST;
			brightness_q <= RST_BRIGHTNESS;
			for (int k = 0; k < NUM_COMP; k++) begin
				offset_q[k] <= RST_OFFSET;
			end
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				REG_MIX_MODE:   mix_mode_q   <= pwdata[2:0];
				REG_MIX_PCT:    mix_pct_q    <= pwdata[6:0];
				REG_EFFECTS:    effects_q    <= pwdata[1:0];
				REG_CONTRAST:   contrast_q   <= pwdata[7:0];
				REG_BRIGHTNESS: brightness_q <= pwdata[7:0];
				REG_OFFSET_C0:  offset_q[0]  <= pwdata[7:0];
				REG_OFFSET_C1:  offset_q[1]  <= pwdata[7:0];
				REG_OFFSET_C2:  offset_q[2]  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register, zero extended
	always_comb begin
		prdata = '0;
		unique case (cfg_idx)
			REG_MIX_MODE:   prdata[2:0] = mix_mode_q;
			REG_MIX_PCT:    prdata[6:0] = mix_pct_q;
			REG_EFFECTS:    prdata[1:0] = effects_q;
			REG_CONTRAST:   prdata[7:0] = contrast_q;
			REG_BRIGHTNESS: prdata[7:0] = brightness_q;
			REG_OFFSET_C0:  prdata[7:0] = offset_q[0];
			REG_OFFSET_C1:  prdata[7:0] = offset_q[1];
			REG_OFFSET_C2:  prdata[7:0] = offset_q[2];
			default: ;
		endcase
	end

	// Datapath settings; users must change them only in an empty pipe (unchecked)
	logic [6:0] pct_a;
	logic [6:0] pct_s;
	logic       mode_div;

	assign pct_a    = (mix_pct_q > PCT_FULL) ? PCT_FULL : mix_pct_q;
	assign pct_s    = PCT_FULL - pct_a;
	assign mode_div = (mix_mode_q == MODE_ADD) || (mix_mode_q == MODE_SUB);

	// ---------------------------------------------------------------------
	// Request side: never stalls
	// ---------------------------------------------------------------------
	logic       accept;
	logic [7:0] in_a [NUM_COMP];
	logic [7:0] in_s [NUM_COMP];

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	assign in_a[0] = first_c0;
	assign in_a[1] = first_c1;
	assign in_a[2] = first_c2;
	assign in_s[0] = second_c0;
	assign in_s[1] = second_c1;
	assign in_s[2] = second_c2;

	// Valid bits travel alongside the payload
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: weighted and plain products
	// ---------------------------------------------------------------------
	logic [7:0]  a_s1  [NUM_COMP];
	logic [7:0]  s_s1  [NUM_COMP];
	logic [14:0] pa_s1 [NUM_COMP];
	logic [14:0] ps_s1 [NUM_COMP];
	logic [15:0] as_s1 [NUM_COMP];

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_COMP; k++) begin
			a_s1[k]  <= in_a[k];
			s_s1[k]  <= in_s[k];
			pa_s1[k] <= 15'(pct_a * in_a[k]);
			ps_s1[k] <= 15'(pct_s * in_s[k]);
			as_s1[k] <= in_a[k] * in_s[k];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: combine add/subtract, start divide by 100; multiply path /255
	// ---------------------------------------------------------------------
	logic [DIV_IN_W-1:0]   n_mix  [NUM_COMP];
	logic                  neg_mix[NUM_COMP];
	logic [7:0]            byp_mix[NUM_COMP];
	logic [DIV_PROD_W-1:0] prod_s2[NUM_COMP];
	logic                  neg_s2 [NUM_COMP];
	logic [7:0]            byp_s2 [NUM_COMP];
	logic                  div_s2;

	always_comb begin
		logic [15:0] add_sum;
		logic [15:0] sub_sum;
		logic [16:0] m255;
		for (int k = 0; k < NUM_COMP; k++) begin
			add_sum    = 16'(pa_s1[k]) + 16'(ps_s1[k]) + 16'(ROUND_HALF);
			sub_sum    = 16'(pa_s1[k]) + 16'(ROUND_HALF);
			// floor(x/255) for x up to 255*255, the largest product
			m255       = 17'(as_s1[k]) + 17'(as_s1[k][15:8]) + 17'd1;
			if (mix_mode_q == MODE_SUB) begin
				neg_mix[k] = sub_sum < 16'(ps_s1[k]);
				n_mix[k]   = DIV_IN_W'(sub_sum - 16'(ps_s1[k]));
			end else begin
				neg_mix[k] = 1'b0;
				n_mix[k]   = add_sum[DIV_IN_W-1:0];
			end
			priority if (mix_mode_q == MODE_CH2) begin
				byp_mix[k] = s_s1[k];
			end else if (mix_mode_q == MODE_MUL) begin
				byp_mix[k] = m255[15:8];
			end else begin
				byp_mix[k] = a_s1[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		div_s2 <= mode_div;
		for (int k = 0; k < NUM_COMP; k++) begin
			prod_s2[k] <= n_mix[k] * DIV100_MUL;
			neg_s2[k]  <= neg_mix[k];
			byp_s2[k]  <= byp_mix[k];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: pick the mixed value, apply contrast gain
	// ---------------------------------------------------------------------
	logic [7:0]  x_mix[NUM_COMP];
	logic [7:0]  x_s3 [NUM_COMP];
	logic [15:0] xc_s3[NUM_COMP];

	always_comb begin
		for (int k = 0; k < NUM_COMP; k++) begin
			priority if (!div_s2) begin
				x_mix[k] = byp_s2[k];
			end else if (neg_s2[k]) begin
				x_mix[k] = '0;
			end else begin
				x_mix[k] = quot_sat(prod_s2[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_COMP; k++) begin
			x_s3[k]  <= x_mix[k];
			xc_s3[k] <= x_mix[k] * contrast_q;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 4: add brightness, round, start divide by 100
	// ---------------------------------------------------------------------
	logic [16:0]           bright_term;
	logic [DIV_IN_W-1:0]   n_cb  [NUM_COMP];
	logic                  neg_cb[NUM_COMP];
	logic                  sat_cb[NUM_COMP];
	logic [7:0]            x_s4   [NUM_COMP];
	logic [DIV_PROD_W-1:0] prod_s4[NUM_COMP];
	logic                  neg_s4 [NUM_COMP];
	logic                  sat_s4 [NUM_COMP];

	// 100*b, built from shifts
	assign bright_term = (17'(brightness_q) << 6) + (17'(brightness_q) << 5)
		+ (17'(brightness_q) << 2);

	always_comb begin
		logic [16:0] sum;
		logic [16:0] n;
		for (int k = 0; k < NUM_COMP; k++) begin
			sum       = 17'(xc_s3[k]) + 17'(ROUND_HALF) + bright_term;
			n         = sum - BRIGHT_BIAS;
			neg_cb[k] = sum < BRIGHT_BIAS;
			sat_cb[k] = n >= SAT_LIMIT;
			n_cb[k]   = n[DIV_IN_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_COMP; k++) begin
			x_s4[k]    <= x_s3[k];
			prod_s4[k] <= n_cb[k] * DIV100_MUL;
			neg_s4[k]  <= neg_cb[k];
			sat_s4[k]  <= sat_cb[k];
		end
	end

	// ---------------------------------------------------------------------
	// Stage 5: finish contrast/brightness, add offset, clamp offset result to 0..254
	// ---------------------------------------------------------------------
	logic [7:0] y_fx [NUM_COMP];
	logic [7:0] z_fx [NUM_COMP];
	logic [7:0] out_s5[NUM_COMP];

	always_comb begin
		logic [8:0] z;
		for (int k = 0; k < NUM_COMP; k++) begin
			priority if (!effects_q[0]) begin
				y_fx[k] = x_s4[k];
			end else if (neg_s4[k]) begin
				y_fx[k] = '0;
			end else if (sat_s4[k]) begin
				y_fx[k] = PIX_MAX;
			end else begin
				y_fx[k] = quot_sat(prod_s4[k]);
			end
			z = 9'(y_fx[k]) + 9'(offset_q[k]);
			priority if (!effects_q[1]) begin
				z_fx[k] = y_fx[k];
			end else if (z < 9'(PCT_FULL)) begin
				z_fx[k] = '0;
			end else if ((z - 9'(PCT_FULL)) > 9'(OFS_PIX_MAX)) begin
				z_fx[k] = OFS_PIX_MAX;
			end else begin
				z_fx[k] = 8'(z - 9'(PCT_FULL));
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_COMP; k++) begin
			out_s5[k] <= z_fx[k];
		end
	end

	// Present each result for one cycle
	assign done     = v_s5;
	assign mixed_c0 = out_s5[0];
	assign mixed_c1 = out_s5[1];
	assign mixed_c2 = out_s5[2];

endmodule

// ----- dv/tb_two_channel_pixel_mixer_core.sv -----
// Testbench for two_channel_pixel_mixer_core: a directed table, then random pixel requests
// under many register settings, each result checked against an in-bench predictor.
// Depends on tcpm_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_two_channel_pixel_mixer_core;
	import tcpm_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 200000;
	localparam int unsigned PIPE_SETTLE   = 8;	// longer than the pipeline latency
	localparam int unsigned REPORT_LIMIT  = 10;
	localparam int unsigned NUM_REGS      = 8;
	localparam int unsigned RANDOM_PHASES = 9;
	localparam int unsigned PHASE_ITEMS   = 150;

	// Mode codes without a name in the package; both act as channel 1 only
	localparam logic [2:0] MODE_ALIAS_LO = 3'd5;
	localparam logic [2:0] MODE_ALIAS_HI = 3'd7;

	// Effect enable codes
	localparam logic [1:0] FX_NONE     = 2'd0;
	localparam logic [1:0] FX_CONTRAST = 2'd1;
	localparam logic [1:0] FX_OFFSET   = 2'd2;
	localparam logic [1:0] FX_BOTH     = 2'd3;

	// Two complementary pixels, packed as {c2, c1, c0}
	localparam logic [23:0] PIX_A = 24'hFF_5A_00;
	localparam logic [23:0] PIX_B = 24'h00_A5_FF;

	// One full set of register values
	typedef struct packed {
		logic [2:0] mode;
		logic [6:0] pct;
		logic [1:0] fx;
		logic [7:0] gain;
		logic [7:0] bright;
		logic [7:0] ofs0;
		logic [7:0] ofs1;
		logic [7:0] ofs2;
	} mixer_cfg_t;

	// One row of the directed table; want is used only where typed is set
	typedef struct packed {
		mixer_cfg_t  cfg;
		logic [23:0] first;
		logic [23:0] second;
		logic        typed;
		logic [23:0] want;
	} pixel_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [7:0]         first_c0, first_c1, first_c2;
	logic [7:0]         second_c0, second_c1, second_c2;
	logic               done;
	logic [7:0]         mixed_c0, mixed_c1, mixed_c2;
	logic               psel, penable, pwrite;
	logic [ADDR_W-1:0]  paddr;
	logic [DATA_W-1:0]  pwdata;
	logic [DATA_W-1:0]  prdata;
	logic               pready;

	mixer_cfg_t         reset_cfg;
	mixer_cfg_t         live_cfg;	// what the block holds right now
	pixel_row_t         directed_rows[$];
	logic [23:0]        expected_pixels[$];
	int unsigned        gap_pct;
	int unsigned        fail_count;
	int unsigned        pixels_sent;
	int unsigned        results_seen;
	int unsigned        cfg_loads;
	int unsigned        cycle_count;

	two_channel_pixel_mixer_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.first_c0  (first_c0),
		.first_c1  (first_c1),
		.first_c2  (first_c2),
		.second_c0 (second_c0),
		.second_c1 (second_c1),
		.second_c2 (second_c2),
		.done      (done),
		.mixed_c0  (mixed_c0),
		.mixed_c1  (mixed_c1),
		.mixed_c2  (mixed_c2),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Count every failure, print only the first few
	function automatic void note_failure(input string what);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
	endfunction

	function automatic mixer_cfg_t make_cfg(input logic [2:0] mode, input logic [6:0] pct,
		input logic [1:0] fx, input logic [7:0] gain, input logic [7:0] bright,
		input logic [7:0] o0, input logic [7:0] o1, input logic [7:0] o2);
		mixer_cfg_t c;
		c.mode   = mode;
		c.pct    = pct;
		c.fx     = fx;
		c.gain   = gain;
		c.bright = bright;
		c.ofs0   = o0;
		c.ofs1   = o1;
		c.ofs2   = o2;
		return c;
	endfunction

	// Register value as the APB port shows it, zero-extended
	function automatic logic [DATA_W-1:0] cfg_field(input mixer_cfg_t c, input reg_idx_t idx);
		case (idx)
		REG_MIX_MODE:   return DATA_W'(c.mode);
		REG_MIX_PCT:    return DATA_W'(c.pct);
		REG_EFFECTS:    return DATA_W'(c.fx);
		REG_CONTRAST:   return DATA_W'(c.gain);
		REG_BRIGHTNESS: return DATA_W'(c.bright);
		REG_OFFSET_C0:  return DATA_W'(c.ofs0);
		REG_OFFSET_C1:  return DATA_W'(c.ofs1);
		default:        return DATA_W'(c.ofs2);
		endcase
	endfunction

	// n/100 rounded half up; negative gives 0, saturate to a pixel value
	function automatic int div100_rounded_sat(input int n);
		if (n < 0) begin
			return 0;
		end
		return ((n + 50) / 100 > int'(PIX_MAX)) ? int'(PIX_MAX) : (n + 50) / 100;
	endfunction

	// Mix, then contrast/brightness, then offsets; every component on its own
	function automatic logic [23:0] predict_mixed_pixel(input mixer_cfg_t c,
		input logic [23:0] first, input logic [23:0] second);
		logic [23:0] pix;
		logic [7:0]  ofs;
		int          a, s, x, p;
		p = (c.pct > PCT_FULL) ? int'(PCT_FULL) : int'(c.pct);
		for (int k = 0; k < 3; k++) begin
			a = first[8*k +: 8];
			s = second[8*k +: 8];
			case (c.mode)
			MODE_CH2: x = s;
			MODE_ADD: x = div100_rounded_sat(p * a + (100 - p) * s);
			MODE_SUB: x = div100_rounded_sat(p * a - (100 - p) * s);
			MODE_MUL: x = (a * s) / int'(PIX_MAX);
			default:  x = a;
			endcase
			if (c.fx[0]) begin
				x = div100_rounded_sat(x * int'(c.gain) + 100 * (int'(c.bright) - 100));
			end
			if (c.fx[1]) begin
				ofs = (k == 0) ? c.ofs0 : (k == 1) ? c.ofs1 : c.ofs2;
				x = x + int'(ofs) - 100;
				x = (x < 0) ? 0 : (x > int'(OFS_PIX_MAX)) ? int'(OFS_PIX_MAX) : x;
			end
			pix[8*k +: 8] = x[7:0];
		end
		return pix;
	endfunction

	// Favor the edges: zero, the field top, the neutral 100, else anything
	function automatic logic [7:0] pick_setting(input logic [7:0] top);
		case ($urandom_range(0, 5))
		0:       return 8'd0;
		1:       return top;
		2:       return 8'd100;
		default: return 8'($urandom_range(0, top));
		endcase
	endfunction

	function automatic mixer_cfg_t random_cfg();
		mixer_cfg_t c;
		// half the time one of the arithmetic modes, else any code at all
		if ($urandom_range(0, 1) == 1) begin
			c.mode = 3'($urandom_range(int'(MODE_ADD), int'(MODE_MUL)));
		end else begin
			c.mode = 3'($urandom_range(0, 7));
		end
		c.pct    = 7'(pick_setting(8'd127));
		c.fx     = 2'($urandom_range(int'(FX_NONE), int'(FX_BOTH)));
		c.gain   = pick_setting(8'd255);
		c.bright = pick_setting(8'd255);
		c.ofs0   = pick_setting(8'd255);
		c.ofs1   = pick_setting(8'd255);
		c.ofs2   = pick_setting(8'd255);
		return c;
	endfunction

	function automatic logic [23:0] random_pixel();
		logic [23:0] pix;
		for (int k = 0; k < 3; k++) begin
			case ($urandom_range(0, 7))
			0:       pix[8*k +: 8] = 8'h00;
			1:       pix[8*k +: 8] = 8'hFF;
			default: pix[8*k +: 8] = 8'($urandom_range(0, 255));
			endcase
		end
		return pix;
	endfunction

	task automatic add_row(input mixer_cfg_t c, input logic [23:0] first,
		input logic [23:0] second, input logic typed, input logic [23:0] want);
		directed_rows.push_back({c, first, second, typed, want});
	endtask

	// APB transfers leave psel high so the next one can follow straight on;
	// the caller drops the port afterwards.
	task automatic apb_write(input reg_idx_t idx, input logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apb_read(input reg_idx_t idx, output logic [DATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
	endtask

	// Read every register back, compare with the shadow copy, then drop the port
	task automatic verify_cfg_readback();
		logic [DATA_W-1:0] rd;
		for (int i = 0; i < NUM_REGS; i++) begin
			apb_read(reg_idx_t'(i), rd);
			if (rd !== cfg_field(live_cfg, reg_idx_t'(i))) begin
				note_failure($sformatf("register %0d read %0h, expected %0h", i, rd,
					cfg_field(live_cfg, reg_idx_t'(i))));
			end
		end
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Only called with the pipeline empty
	task automatic load_cfg(input mixer_cfg_t c);
		for (int i = 0; i < NUM_REGS; i++) begin
			apb_write(reg_idx_t'(i), cfg_field(c, reg_idx_t'(i)));
		end
		live_cfg = c;
		cfg_loads++;
		verify_cfg_readback();
	endtask

	// Drop start and hold until every pending pixel has come back
	task automatic hold_until_drained();
		start <= 1'b0;
		do @(posedge clk); while (expected_pixels.size() != 0);
	endtask

	// Present one request, maybe after a random gap, and hold it until accepted.
	// start stays high afterwards so back-to-back requests need no extra edge.
	task automatic send_pixel(input logic [23:0] first, input logic [23:0] second,
		input logic typed, input logic [23:0] want);
		while ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		{first_c2, first_c1, first_c0}    <= first;
		{second_c2, second_c1, second_c0} <= second;
		do @(posedge clk); while (busy);
		expected_pixels.push_back(typed ? want : predict_mixed_pixel(live_cfg, first, second));
		pixels_sent++;
	endtask

	// Result checker: the block cannot be stalled, so sample every strobe
	always @(posedge clk) begin
		logic [23:0] got, want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			got = {mixed_c2, mixed_c1, mixed_c0};
			results_seen++;
			if (expected_pixels.size() == 0) begin
				note_failure($sformatf("result %h with no request pending", got));
			end else begin
				want = expected_pixels.pop_front();
				for (int k = 0; k < 3; k++) begin
					if (got[8*k +: 8] !== want[8*k +: 8]) begin
						note_failure($sformatf("result %0d mixed_c%0d expected %0d got %0d",
							results_seen, k, want[8*k +: 8], got[8*k +: 8]));
					end
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				expected_pixels.size());
			$display("FAIL two_channel_pixel_mixer_core");
			$finish;
		end
	end

	initial begin
		mixer_cfg_t c;
		fail_count   = 0;
		pixels_sent  = 0;
		results_seen = 0;
		cfg_loads    = 0;
		cycle_count  = 0;
		gap_pct      = 11;
		reset_cfg    = make_cfg(RST_MIX_MODE, RST_MIX_PCT, RST_EFFECTS, RST_CONTRAST,
			RST_BRIGHTNESS, RST_OFFSET, RST_OFFSET, RST_OFFSET);
		live_cfg     = reset_cfg;

		// Every input known from time zero
		arst_n    <= 1'b0;
		start     <= 1'b0;
		{first_c2, first_c1, first_c0}    <= '0;
		{second_c2, second_c1, second_c0} <= '0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;

		// Directed table. Typed rows carry a result that follows directly from
		// the settings; the rest go through the predictor.
		c = reset_cfg;
		add_row(c, PIX_A, PIX_B, 1'b1, PIX_A);
		add_row(c, PIX_B, PIX_A, 1'b1, PIX_B);
		c.mode = MODE_CH2;
		add_row(c, PIX_A, PIX_B, 1'b1, PIX_B);
		// multiply: full times full stays full, zero wipes out
		c.mode = MODE_MUL;
		add_row(c, 24'hFF_00_FF, 24'h00_FF_FF, 1'b1, 24'h00_00_FF);
		add_row(c, 24'h80_40_C8, 24'h7F_FF_03, 1'b0, '0);
		// weighted add at full weight, zero weight and a weight past 100
		c.mode = MODE_ADD;
		c.pct  = PCT_FULL;
		add_row(c, 24'h12_34_56, 24'hFE_DC_BA, 1'b1, 24'h12_34_56);
		c.pct  = 7'd0;
		add_row(c, 24'h12_34_56, 24'hFE_DC_BA, 1'b1, 24'hFE_DC_BA);
		c.pct  = 7'd127;
		add_row(c, 24'h12_34_56, 24'hFE_DC_BA, 1'b1, 24'h12_34_56);
		c.pct  = 7'd50;
		add_row(c, 24'hFF_01_00, 24'hFF_00_01, 1'b0, '0);
		// weighted subtract, including a negative difference clamped to zero
		c.mode = MODE_SUB;
		c.pct  = PCT_FULL;
		add_row(c, PIX_A, PIX_B, 1'b1, PIX_A);
		c.pct  = 7'd0;
		add_row(c, 24'hFF_FF_FF, 24'h00_01_FF, 1'b1, 24'h00_00_00);
		c.pct  = 7'd50;
		add_row(c, 24'hFF_80_FF, 24'h00_7F_01, 1'b0, '0);
		// unnamed mode codes fall back to channel 1
		c.mode = MODE_ALIAS_LO;
		add_row(c, PIX_B, PIX_A, 1'b1, PIX_B);
		c.mode = MODE_ALIAS_HI;
		add_row(c, PIX_A, PIX_B, 1'b1, PIX_A);
		// contrast/brightness: all dark, strongest gain, neutral, beyond range
		c = reset_cfg;
		c.fx     = FX_CONTRAST;
		c.gain   = 8'd0;
		c.bright = 8'd0;
		add_row(c, 24'hFF_80_00, PIX_B, 1'b1, 24'h00_00_00);
		c.gain   = 8'd255;
		c.bright = 8'd200;
		add_row(c, 24'hFF_01_00, PIX_B, 1'b0, '0);
		c.gain   = 8'd100;
		c.bright = 8'd100;
		add_row(c, 24'h9C_01_FE, PIX_A, 1'b1, 24'h9C_01_FE);
		c.gain   = 8'd255;
		c.bright = 8'd255;
		add_row(c, 24'h7F_02_01, PIX_A, 1'b0, '0);
		// offsets: clamp at 254 on top and at zero below
		c = reset_cfg;
		c.fx   = FX_OFFSET;
		c.ofs0 = 8'd0;
		c.ofs1 = 8'd100;
		c.ofs2 = 8'd200;
		add_row(c, 24'hFF_FF_FF, PIX_A, 1'b1, 24'hFE_FE_9B);
		c.ofs1 = 8'd0;
		c.ofs2 = 8'd0;
		add_row(c, 24'h00_63_64, PIX_A, 1'b1, 24'h00_00_00);
		c.ofs0 = 8'd255;
		c.ofs1 = 8'd255;
		c.ofs2 = 8'd255;
		add_row(c, 24'h00_00_FF, PIX_A, 1'b0, '0);
		// both stages behind an arithmetic mix
		c = make_cfg(MODE_ADD, 7'd30, FX_BOTH, 8'd255, 8'd0, 8'd200, 8'd50, 8'd150);
		add_row(c, 24'hC0_80_40, 24'h10_F0_7F, 1'b0, '0);
		c = make_cfg(MODE_MUL, 7'd50, FX_BOTH, 8'd50, 8'd150, 8'd100, 8'd100, 8'd100);
		add_row(c, 24'hFF_80_FF, 24'hFF_FF_40, 1'b0, '0);
		add_row(reset_cfg, PIX_B, PIX_A, 1'b1, PIX_B);

		// Hold reset, then release it on a clock edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		verify_cfg_readback();

		// Walk the table; reload registers only when a row asks for new settings
		foreach (directed_rows[i]) begin
			if (directed_rows[i].cfg != live_cfg) begin
				hold_until_drained();
				load_cfg(directed_rows[i].cfg);
			end
			send_pixel(directed_rows[i].first, directed_rows[i].second,
				directed_rows[i].typed, directed_rows[i].want);
		end

		// Random traffic. Sender gaps: light, then heavy, then none. The first
		// and last phases pin weight, gain, brightness and offsets to top and bottom.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			gap_pct = (ph < 3) ? 11 : (ph < 6) ? 50 : 0;
			hold_until_drained();
			if (ph == 0) begin
				load_cfg(make_cfg(MODE_SUB, 7'd127, FX_BOTH, 8'd255, 8'd255,
					8'd255, 8'd255, 8'd255));
			end else if (ph == RANDOM_PHASES - 1) begin
				load_cfg(make_cfg(MODE_ADD, 7'd0, FX_BOTH, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0));
			end else begin
				load_cfg(random_cfg());
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// halfway through, let the pipeline run completely dry
				if (n == PHASE_ITEMS / 2) begin
					hold_until_drained();
				end
				send_pixel(random_pixel(), random_pixel(), 1'b0, '0);
			end
		end

		// Drain, then give stray strobes a chance to show up
		hold_until_drained();
		repeat (PIPE_SETTLE) @(posedge clk);

		$display("Sent %0d pixel requests and checked %0d results across %0d register loads,",
			pixels_sent, results_seen, cfg_loads);
		$display("all mix modes, both effect stages and sender gaps of 0, 11 and 50 percent.");
		if (fail_count == 0) begin
			$display("PASS two_channel_pixel_mixer_core");
		end else begin
			$display("%0d failures", fail_count);
			$display("FAIL two_channel_pixel_mixer_core");
		end
		$finish;
	end

endmodule
